### rtl/led_blink_pattern_sequencer_assert.svh
// Assertion macros shared by the checker of the LED blink pattern sequencer.
`ifndef LED_BLINK_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_BLINK_PATTERN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, skipped while reset is asserted.
`define LBPS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lbps assertion failed");

// Next-cycle implication, skipped while reset is asserted.
`define LBPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lbps assertion failed");

// Next-cycle implication that also holds during reset.
`define LBPS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lbps assertion failed");

`endif

### rtl/lbps_pkg.sv
// Types, request codes and pattern tables of the LED blink pattern sequencer.
package lbps_pkg;

    localparam int PIN_W         = 2;
    localparam int PATTERN_COUNT = 7;
    localparam int PHASE_MAX     = 6;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_SET    = 2'd1;
    localparam logic [1:0] REQ_TOGGLE = 2'd2;

    localparam logic [7:0] MODE_NONE = 8'hff;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  led_index;
        logic [7:0]  mode_value;
        logic [15:0] elapsed_ms;
    } lbps_req_t;

    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic             set_rejected;
    } lbps_res_t;

    localparam logic [2:0] PAT_LEN [PATTERN_COUNT] = '{
        3'd0, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd6
    };

    localparam logic [9:0] PAT_MS [PATTERN_COUNT][PHASE_MAX] = '{
        '{10'd0,   10'd0,   10'd0,   10'd0,    10'd0,   10'd0},
        '{10'd0,   10'd50,  10'd0,   10'd0,    10'd0,   10'd0},
        '{10'd50,  10'd0,   10'd0,   10'd0,    10'd0,   10'd0},
        '{10'd50,  10'd50,  10'd0,   10'd0,    10'd0,   10'd0},
        '{10'd200, 10'd200, 10'd0,   10'd0,    10'd0,   10'd0},
        '{10'd200, 10'd200, 10'd200, 10'd1000, 10'd0,   10'd0},
        '{10'd200, 10'd200, 10'd200, 10'd200,  10'd200, 10'd1000}
    };

    // Unknown patterns count as empty.
    function automatic logic [2:0] pat_len(input logic [6:0] pat);
        logic [2:0] len;
        len = 3'd0;
        if (pat < 7'(PATTERN_COUNT)) begin
            len = PAT_LEN[pat[2:0]];
        end
        return len;
    endfunction

    function automatic logic [9:0] pat_ms(input logic [6:0] pat, input logic [2:0] step);
        logic [9:0] ms;
        ms = 10'd0;
        if (pat < 7'(PATTERN_COUNT) && step < 3'(PHASE_MAX)) begin
            ms = PAT_MS[pat[2:0]][step];
        end
        return ms;
    endfunction

endpackage

### rtl/led_blink_pattern_sequencer.sv
// LED blink pattern sequencer: request handling, per-LED pattern timers and pin register.
//
// Requests arrive on the s_ channel (valid/ready, struct s_data): a tick carries the
// milliseconds elapsed, a set queues the next mode of one LED (bit 7 = repeat), a
// toggle forces one LED into manual mode and flips its pin. Every request yields one
// result on the m_ channel: the pin levels of LEDs 0 and 1 after the request and a
// flag that marks a set or toggle with a bad LED index or pattern.
// cfg_wr_en/cfg_wr_data write the polarity mask; write it only while the block is idle.
//
// A request is registered at the input, processed for all LEDs in parallel as soon
// as the result register is empty or being taken, and lands in the result register,
// which drives the m_ channel.
// One request per cycle is sustained while every result is taken; s_ready stays high
// as long as the result register is empty or being taken.
// If the receiver stalls, the result register holds, then the input stage fills and
// s_ready drops. Synchronous reset (aresetn low) empties both stages, sets all pins
// high, clears every LED to manual mode with no queued mode and clears the polarity.
module led_blink_pattern_sequencer #(
    parameter int LED_COUNT = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lbps_pkg::lbps_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lbps_pkg::lbps_res_t m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data
);
    import lbps_pkg::*;

    localparam logic [3:0] LED_LIMIT = 4'(LED_COUNT);

    logic             in_valid_reg;
    lbps_req_t        in_data_reg;
    logic             out_valid_reg;
    lbps_res_t        out_data_reg;
    logic [PIN_W-1:0] pol_reg;
    logic [PIN_W-1:0] pin_reg;
    logic [PIN_W-1:0] pin_next;

    logic [9:0] timer_reg   [LED_COUNT];
    logic [9:0] timer_next  [LED_COUNT];
    logic [2:0] step_reg    [LED_COUNT];
    logic [2:0] step_next   [LED_COUNT];
    logic [7:0] active_reg  [LED_COUNT];
    logic [7:0] active_next [LED_COUNT];
    logic [7:0] queued_reg  [LED_COUNT];
    logic [7:0] queued_next [LED_COUNT];

    logic advance;
    logic fire;
    logic bad_led;
    logic rejected;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        bad_led  = {1'b0, in_data_reg.led_index} >= LED_LIMIT;
        rejected = 1'b0;
        unique case (in_data_reg.req_type)
            REQ_SET: begin
                rejected = bad_led
                    || (in_data_reg.mode_value[6:0] >= 7'(PATTERN_COUNT));
            end
            REQ_TOGGLE: begin
                rejected = bad_led;
            end
            default: begin
                rejected = 1'b0;
            end
        endcase
    end

    always_comb begin
        logic [6:0]  pat;
        logic [6:0]  run_pat;
        logic [2:0]  stp;
        logic        adopt;
        logic        sel;
        logic        drv;
        logic        parity;
        pin_next = pin_reg;
        for (int i = 0; i < LED_COUNT; i++) begin
            timer_next[i]  = timer_reg[i];
            step_next[i]   = step_reg[i];
            active_next[i] = active_reg[i];
            queued_next[i] = queued_reg[i];
            pat     = active_reg[i][6:0];
            run_pat = pat;
            stp     = step_reg[i];
            adopt   = 1'b0;
            drv     = 1'b0;
            parity  = 1'b0;
            sel     = (in_data_reg.led_index == 3'(i)) && !rejected;
            case (in_data_reg.req_type)
                REQ_TICK: begin
                    if (pat == 7'd0) begin
                        if (queued_reg[i] != MODE_NONE) begin
                            active_next[i] = queued_reg[i];
                            queued_next[i] = MODE_NONE;
                            step_next[i]   = 3'd0;
                            timer_next[i]  = 10'd0;
                        end
                    end else if (timer_reg[i] != 10'd0) begin
                        // count down, clamp at zero
                        if ({6'd0, timer_reg[i]} >= in_data_reg.elapsed_ms) begin
                            timer_next[i] = timer_reg[i] - in_data_reg.elapsed_ms[9:0];
                        end else begin
                            timer_next[i] = 10'd0;
                        end
                    end else begin
                        if (step_reg[i] >= pat_len(pat)) begin
                            stp = 3'd0;
                            if (active_reg[i][7]) begin
                                if (queued_reg[i] != MODE_NONE) begin
                                    active_next[i] = queued_reg[i];
                                    queued_next[i] = MODE_NONE;
                                    timer_next[i]  = 10'd0;
                                    step_next[i]   = 3'd0;
                                    adopt          = 1'b1;
                                end
                            end else begin
                                // pattern over: fall back to manual
                                active_next[i] = 8'd0;
                                run_pat        = 7'd0;
                            end
                        end
                        if (!adopt) begin
                            timer_next[i] = pat_ms(run_pat, stp);
                            step_next[i]  = stp + 3'd1;
                            drv           = 1'b1;
                            parity        = stp[0];
                        end
                    end
                end
                REQ_SET: begin
                    if (sel) begin
                        queued_next[i] = in_data_reg.mode_value;
                    end
                end
                REQ_TOGGLE: begin
                    if (sel) begin
                        active_next[i] = 8'd0;
                        step_next[i]   = (step_reg[i] == 3'd0) ? 3'd1 : 3'd0;
                        drv            = 1'b1;
                        parity         = (step_reg[i] == 3'd0);
                    end
                end
                default: begin
                    drv = 1'b0;
                end
            endcase
            if (drv && i < PIN_W) begin
                pin_next[1'(i)] = !(parity ^ pol_reg[1'(i)]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pol_reg       <= '0;
            pin_reg       <= '1;
            for (int i = 0; i < LED_COUNT; i++) begin
                timer_reg[i]  <= 10'd0;
                step_reg[i]   <= 3'd0;
                active_reg[i] <= 8'd0;
                queued_reg[i] <= MODE_NONE;
            end
        end else begin
            if (cfg_wr_en) begin
                pol_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                pin_reg <= pin_next;
                for (int i = 0; i < LED_COUNT; i++) begin
                    timer_reg[i]  <= timer_next[i];
                    step_reg[i]   <= step_next[i];
                    active_reg[i] <= active_next[i];
                    queued_reg[i] <= queued_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg.pin_levels   <= pin_next;
            out_data_reg.set_rejected <= rejected;
        end
    end

endmodule

### rtl/lbps_checker.sv
// Port-level checker of the LED blink pattern sequencer and its bind.
`include "led_blink_pattern_sequencer_assert.svh"

module lbps_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input lbps_pkg::lbps_res_t m_data
);
    import lbps_pkg::*;

    logic in_xfer;
    assign in_xfer = s_valid && s_ready;

    // a stalled result holds
    `LBPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // reset empties the result register
    `LBPS_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_valid)
    // an empty result register never blocks the input
    `LBPS_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    // no result appears without an earlier input transfer
    `LBPS_ASSERT_NEXT(a_no_phantom, aclk, aresetn, !m_valid && !in_xfer && !$past(in_xfer), !m_valid)

endmodule

bind led_blink_pattern_sequencer lbps_checker u_lbps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
